/* rtl/a85hx_pkg.sv */
package a85hx_pkg;

	localparam int unsigned LineLengthDefault = 80;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 17;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_MODE = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_BLOCK_BYTES = 1'b1;

	localparam logic [2:0] ModeRaw = 3'd0;
	localparam logic [2:0] ModeA85Twelve = 3'd1;
	localparam logic [2:0] ModeHexEight = 3'd2;
	localparam logic [2:0] ModeHexTwelve = 3'd3;
	localparam logic [2:0] ModeA85Eight = 3'd4;

	localparam logic [16:0] BlockBytesReset = 17'd4096;
	localparam logic [16:0] BlockBytesMin = 17'd16;
	localparam logic [16:0] BlockBytesMax = 17'd65536;

	// floor(w / 85) = (w * Recip85) >> Recip85Shift for any 32-bit w
	localparam logic [31:0] Recip85 = 32'd3233857729;
	localparam int unsigned Recip85Shift = 38;

	localparam logic [7:0] ChBase = 8'd33;
	localparam logic [7:0] ChZ = 8'h7A;
	localparam logic [7:0] ChTilde = 8'h7E;
	localparam logic [7:0] ChGt = 8'h3E;
	localparam logic [7:0] ChNl = 8'h0A;

	typedef enum logic [2:0] {
		CMD_RAW,
		CMD_HEX,
		CMD_A85,
		CMD_CLR,
		CMD_MARK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [31:0] data;
		logic forced;
		logic [2:0] keep;
		logic eoi;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [16:0] block_bytes;
	} cfg_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) c = 8'h30 + {4'h0, n};
		else c = 8'h37 + {4'h0, n};
		return c;
	endfunction

	function automatic logic [2:0] trim_of(input logic [2:0] p);
		logic [2:0] t;
		unique case (p)
			3'd0: t = 3'd0;
			3'd1: t = 3'd2;
			3'd2: t = 3'd1;
			3'd3: t = 3'd3;
			3'd4: t = 3'd2;
			3'd5: t = 3'd5;
			3'd6: t = 3'd3;
			3'd7: t = 3'd1;
			default: t = 3'd0;
		endcase
		return t;
	endfunction

endpackage

/* rtl/a85hx_if.sv */
interface a85hx_in_if;
	logic valid;
	logic ready;
	logic [15:0] data_word;
	logic end_of_stream;

	modport source(output valid, output data_word, output end_of_stream, input ready);
	modport sink(input valid, input data_word, input end_of_stream, output ready);
endinterface

interface a85hx_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_char;
	logic last_of_run;

	modport source(output valid, output out_char, output last_of_run, input ready);
	modport sink(input valid, input out_char, input last_of_run, output ready);
endinterface

/* rtl/ascii85_hex_stream_encoder.sv */
// Byte/sample to ASCII85 or hex text encoder, with a raw byte passthrough mode. The front
// end handles each accepted word as one step, except a 12-bit sample that completes a pair,
// which it steps through one packed byte at a time. Output runs at one char per cycle while
// chars.ready is high, so the sustained rate is set by the char count per word. A group's
// five ascii85 digits (a zero group is sent as one z char) come from one shared divide-by-85
// unit, which works them all out before they are sent. Each newline, end marker char and block
// restart also takes a serializer step. A four-entry command queue between front end and
// serializer lets input keep flowing while chars drain.
module ascii85_hex_stream_encoder #(
	parameter int unsigned LINE_LENGTH = a85hx_pkg::LineLengthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [a85hx_pkg::CfgIdxW-1:0] cfg_idx,
	input logic [a85hx_pkg::CfgDataW-1:0] cfg_data,
	a85hx_in_if.sink samples,
	a85hx_out_if.source chars
);
	import a85hx_pkg::*;

	cfg_t cfg_q;
	cmd_t f_cmd;
	logic f_valid;
	logic f_ready;
	cmd_t b_cmd;
	logic b_valid;
	logic b_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= ModeRaw;
			cfg_q.block_bytes <= BlockBytesReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE: cfg_q.mode <= cfg_data[2:0];
				REG_BLOCK_BYTES: cfg_q.block_bytes <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	a85hx_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.clr(cfg_we),
		.samples(samples),
		.cmd(f_cmd),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready)
	);

	a85hx_queue #(
		.DEPTH(QueueDepth)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_cmd(f_cmd),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.pop_cmd(b_cmd),
		.pop_valid(b_valid),
		.pop_ready(b_ready)
	);

	a85hx_back #(
		.LINE_LENGTH(LINE_LENGTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.clr(cfg_we),
		.q_cmd(b_cmd),
		.q_valid(b_valid),
		.q_ready(b_ready),
		.chars(chars)
	);

endmodule

/* rtl/a85hx_queue.sv */
module a85hx_queue #(
	parameter int unsigned DEPTH = a85hx_pkg::QueueDepth
) (
	input logic clk,
	input logic arst_n,
	input a85hx_pkg::cmd_t push_cmd,
	input logic push_valid,
	output logic push_ready,
	output a85hx_pkg::cmd_t pop_cmd,
	output logic pop_valid,
	input logic pop_ready
);
	import a85hx_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	cmd_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (cnt_q != CntW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_cmd = mem_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
			if (do_pop) rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
		end
	end

endmodule

/* rtl/a85hx_front.sv */
module a85hx_front (
	input logic clk,
	input logic arst_n,
	input a85hx_pkg::cfg_t cfg,
	input logic clr,
	a85hx_in_if.sink samples,
	output a85hx_pkg::cmd_t cmd,
	output logic cmd_valid,
	input logic cmd_ready
);
	import a85hx_pkg::*;

	typedef enum logic [2:0] {F_IDLE, F_NORM, F_CLR, F_PAD, F_FIN, F_MARK} phase_t;

	function automatic phase_t next_ph(input phase_t from, input logic hn, input logic w,
			input logic e, input logic p, input logic a);
		phase_t r;
		if (from < F_NORM && hn) r = F_NORM;
		else if (from < F_CLR && w) r = F_CLR;
		else if (from < F_PAD && e && p) r = F_PAD;
		else if (from < F_FIN && e && a) r = F_FIN;
		else if (from < F_MARK && e) r = F_MARK;
		else r = F_IDLE;
		return r;
	endfunction

	phase_t ph_q;
	logic [1:0] j_q;
	logic [1:0] nn_q;
	logic [7:0] wb_q [6];
	logic wrap_q;
	logic eos_q;
	logic pad_q;
	logic [2:0] keep_q;
	logic [31:0] grp_q;
	logic [1:0] fill_q;
	logic [11:0] held_q;
	logic [2:0] sph_q;
	logic [16:0] bfill_q;

	logic is_raw;
	logic twelve;
	logic a85;
	logic [16:0] bs;
	logic [7:0] cur_b;
	logic [31:0] grp_nx;
	logic need_push;
	logic last_in;
	logic step_go;
	phase_t nxt;
	logic item_done;
	logic mark_done;
	logic accept;
	logic [2:0] eff_sph;
	logic [16:0] eff_bf;
	logic [11:0] s;
	logic odd;
	logic [11:0] h_new;
	logic [2:0] nsph;
	logic [16:0] bf_add;
	logic a_wrap;
	logic [1:0] a_nn;
	logic a_pad;
	logic a_eos;
	phase_t first;

	assign is_raw = (cfg.mode == ModeRaw) || (cfg.mode > ModeA85Eight);
	assign twelve = (cfg.mode == ModeA85Twelve) || (cfg.mode == ModeHexTwelve);
	assign a85 = (cfg.mode == ModeA85Twelve) || (cfg.mode == ModeA85Eight);

	always_comb begin
		bs = cfg.block_bytes;
		if (bs < BlockBytesMin) bs = BlockBytesMin;
		if (bs > BlockBytesMax) bs = BlockBytesMax;
		if (a85) bs[3:0] = 4'h0;
		else if (cfg.mode == ModeHexTwelve) bs[1:0] = 2'b00;
	end

	assign cur_b = (ph_q == F_PAD) ? wb_q[3'd3 + {1'b0, j_q}] : wb_q[{1'b0, j_q}];
	assign grp_nx = {grp_q[23:0], cur_b};

	always_comb begin
		cmd = '0;
		cmd.kind = CMD_RAW;
		cmd.keep = 3'd5;
		need_push = 1'b0;
		last_in = 1'b1;
		unique case (ph_q)
			F_IDLE: last_in = 1'b0;
			F_NORM: begin
				last_in = (j_q == nn_q - 2'd1);
				cmd.data = {24'h0, cur_b};
				if (is_raw) begin
					need_push = 1'b1;
					cmd.eoi = 1'b1;
				end else if (!a85) begin
					need_push = 1'b1;
					cmd.kind = CMD_HEX;
					cmd.eoi = !eos_q && last_in;
				end else begin
					need_push = (fill_q == 2'd3);
					cmd.kind = CMD_A85;
					cmd.data = grp_nx;
					cmd.eoi = !eos_q;
				end
			end
			F_CLR: begin
				need_push = 1'b1;
				cmd.kind = CMD_CLR;
			end
			F_PAD: begin
				last_in = (j_q == 2'd2);
				if (!a85) begin
					need_push = 1'b1;
					cmd.kind = CMD_HEX;
					cmd.data = {24'h0, cur_b};
				end else begin
					need_push = (fill_q == 2'd3);
					cmd.kind = CMD_A85;
					cmd.data = grp_nx;
					cmd.forced = (j_q == 2'd2);
					cmd.keep = (j_q == 2'd2) ? keep_q : 3'd5;
				end
			end
			F_FIN: begin
				need_push = (fill_q != 2'd0);
				cmd.kind = CMD_A85;
				cmd.forced = 1'b1;
				cmd.keep = (cfg.mode == ModeA85Eight) ? {1'b0, fill_q} + 3'd1 : keep_q;
				unique case (fill_q)
					2'd1: cmd.data = {grp_q[7:0], 24'h0};
					2'd2: cmd.data = {grp_q[15:0], 16'h0};
					2'd3: cmd.data = {grp_q[23:0], 8'h0};
					default: cmd.data = grp_q;
				endcase
			end
			F_MARK: begin
				need_push = 1'b1;
				cmd.kind = CMD_MARK;
				cmd.forced = a85;
				cmd.eoi = 1'b1;
			end
			default: last_in = 1'b0;
		endcase
	end

	assign step_go = (ph_q != F_IDLE) && (!need_push || cmd_ready);
	assign cmd_valid = (ph_q != F_IDLE) && need_push;
	assign nxt = next_ph(ph_q, nn_q != 2'd0, wrap_q, eos_q, pad_q, a85);
	assign item_done = step_go && last_in && (nxt == F_IDLE);
	assign mark_done = step_go && (ph_q == F_MARK);
	assign samples.ready = (ph_q == F_IDLE) || item_done;
	assign accept = samples.valid && samples.ready;

	// a finishing end of stream clears the stream state under the next word
	assign eff_sph = mark_done ? 3'd0 : sph_q;
	assign eff_bf = mark_done ? 17'd0 : bfill_q;
	assign s = samples.data_word[11:0];
	assign odd = eff_sph[0];
	assign h_new = odd ? held_q : s;
	assign nsph = eff_sph + 3'd1;
	assign bf_add = eff_bf + (twelve ? 17'd2 : 17'd1);
	assign a_wrap = !is_raw && (bf_add >= bs);
	assign a_nn = is_raw ? 2'd1 : (twelve ? (odd ? 2'd3 : 2'd0) : 2'd1);
	assign a_pad = twelve && !odd;
	assign a_eos = samples.end_of_stream && !is_raw;
	assign first = next_ph(F_IDLE, a_nn != 2'd0, a_wrap, a_eos, a_pad, a85);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= F_IDLE;
			j_q <= '0;
			grp_q <= '0;
			fill_q <= '0;
			held_q <= '0;
			sph_q <= '0;
			bfill_q <= '0;
		end else if (clr) begin
			ph_q <= F_IDLE;
			j_q <= '0;
			grp_q <= '0;
			fill_q <= '0;
			held_q <= '0;
			sph_q <= '0;
			bfill_q <= '0;
		end else begin
			if (step_go) begin
				if ((ph_q == F_NORM || ph_q == F_PAD) && a85 && !is_raw) begin
					if (fill_q == 2'd3) begin
						grp_q <= '0;
						fill_q <= '0;
					end else begin
						grp_q <= grp_nx;
						fill_q <= fill_q + 2'd1;
					end
				end
				if (ph_q == F_MARK) begin
					grp_q <= '0;
					fill_q <= '0;
					held_q <= '0;
					sph_q <= '0;
					bfill_q <= '0;
				end
				if (last_in) begin
					ph_q <= nxt;
					j_q <= '0;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
			if (accept) begin
				if (is_raw) begin
					if (samples.end_of_stream) begin
						grp_q <= '0;
						fill_q <= '0;
						held_q <= '0;
						sph_q <= '0;
						bfill_q <= '0;
					end
				end else begin
					if (twelve) begin
						held_q <= h_new;
						sph_q <= nsph;
					end
					bfill_q <= a_wrap ? 17'd0 : bf_add;
				end
				ph_q <= first;
				j_q <= '0;
				nn_q <= a_nn;
				wrap_q <= a_wrap;
				eos_q <= a_eos;
				pad_q <= a_pad;
				keep_q <= 3'd5 - trim_of(nsph);
				if (twelve) begin
					wb_q[0] <= held_q[11:4];
					wb_q[1] <= {held_q[3:0], s[11:8]};
					wb_q[2] <= s[7:0];
				end else begin
					wb_q[0] <= samples.data_word[7:0];
					wb_q[1] <= 8'h00;
					wb_q[2] <= 8'h00;
				end
				wb_q[3] <= h_new[11:4];
				wb_q[4] <= {h_new[3:0], 4'h0};
				wb_q[5] <= 8'h00;
			end
		end
	end

endmodule

/* rtl/a85hx_back.sv */
module a85hx_back #(
	parameter int unsigned LINE_LENGTH = a85hx_pkg::LineLengthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic clr,
	input a85hx_pkg::cmd_t q_cmd,
	input logic q_valid,
	output logic q_ready,
	a85hx_out_if.source chars
);
	import a85hx_pkg::*;

	localparam int unsigned ColW = $clog2(LINE_LENGTH + 1);

	typedef enum logic [1:0] {B_IDLE, B_CONV, B_EMIT, B_NL} bstate_t;

	bstate_t st_q;
	cmd_kind_t kind_q;
	logic [7:0] byte_q;
	logic [31:0] w_q;
	logic [6:0] d_q [5];
	logic [2:0] cnt_q;
	logic [2:0] n_q;
	logic end_q;
	logic mk2_q;
	logic z_q;
	logic nl_last_q;
	logic nl_fin_q;
	logic [ColW-1:0] col_q;
	logic ov_q;
	logic [7:0] oc_q;
	logic ol_q;

	logic adv;
	logic last_ch;
	logic counted;
	logic [ColW-1:0] col_inc;
	logic nl_hit;
	logic [7:0] ch;
	logic finishing;
	logic load;
	logic [63:0] prod;
	logic [63-Recip85Shift:0] quo;
	logic [31:0] qx;
	logic [31:0] rem;

	assign chars.valid = ov_q;
	assign chars.out_char = oc_q;
	assign chars.last_of_run = ol_q;

	assign adv = !ov_q || chars.ready;
	assign last_ch = (cnt_q == n_q - 3'd1);
	assign counted = (kind_q == CMD_HEX) || (kind_q == CMD_A85);
	assign col_inc = col_q + ColW'(1);
	assign nl_hit = counted && (col_inc >= ColW'(LINE_LENGTH));

	always_comb begin
		unique case (kind_q)
			CMD_HEX: ch = hex_char((cnt_q == 3'd0) ? byte_q[7:4] : byte_q[3:0]);
			CMD_A85: ch = z_q ? ChZ : ChBase + {1'b0, d_q[cnt_q]};
			CMD_MARK: ch = (mk2_q && cnt_q == 3'd0) ? ChTilde : ChGt;
			default: ch = byte_q;
		endcase
	end

	assign finishing = adv && (((st_q == B_EMIT) && last_ch && !nl_hit) ||
		((st_q == B_NL) && nl_fin_q));
	assign load = q_valid && ((st_q == B_IDLE) || finishing);
	assign q_ready = load;

	// base-85 digits are produced least significant first; the last step also stores the top digit
	assign prod = {32'h0, w_q} * {32'h0, Recip85};
	assign quo = prod[63:Recip85Shift];
	assign qx = 32'(quo);
	assign rem = w_q - ((qx << 6) + (qx << 4) + (qx << 2) + qx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			cnt_q <= '0;
			col_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (chars.ready) ov_q <= 1'b0;
			if (clr) col_q <= '0;
			unique case (st_q)
				B_IDLE: ;
				B_CONV: begin
					d_q[3'd4 - cnt_q] <= rem[6:0];
					w_q <= qx;
					if (cnt_q == 3'd3) begin
						d_q[0] <= quo[6:0];
						cnt_q <= '0;
						st_q <= B_EMIT;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				B_EMIT: begin
					if (adv) begin
						ov_q <= 1'b1;
						oc_q <= ch;
						if (nl_hit) begin
							col_q <= '0;
							ol_q <= 1'b0;
							nl_last_q <= end_q && last_ch;
							nl_fin_q <= last_ch;
							cnt_q <= cnt_q + 3'd1;
							st_q <= B_NL;
						end else begin
							ol_q <= end_q && last_ch;
							if (counted) col_q <= col_inc;
							if (last_ch) begin
								st_q <= B_IDLE;
								if (kind_q == CMD_MARK) col_q <= '0;
							end else begin
								cnt_q <= cnt_q + 3'd1;
							end
						end
					end
				end
				B_NL: begin
					if (adv) begin
						ov_q <= 1'b1;
						oc_q <= ChNl;
						ol_q <= nl_last_q;
						st_q <= nl_fin_q ? B_IDLE : B_EMIT;
					end
				end
				default: st_q <= B_IDLE;
			endcase
			if (load) begin
				kind_q <= q_cmd.kind;
				byte_q <= q_cmd.data[7:0];
				end_q <= q_cmd.eoi;
				mk2_q <= q_cmd.forced;
				z_q <= 1'b0;
				cnt_q <= '0;
				unique case (q_cmd.kind)
					CMD_CLR: begin
						col_q <= '0;
						st_q <= B_IDLE;
					end
					CMD_RAW: begin
						n_q <= 3'd1;
						st_q <= B_EMIT;
					end
					CMD_HEX: begin
						n_q <= 3'd2;
						st_q <= B_EMIT;
					end
					CMD_A85: begin
						if (!q_cmd.forced && q_cmd.data == 32'h0) begin
							z_q <= 1'b1;
							n_q <= 3'd1;
							st_q <= B_EMIT;
						end else if (q_cmd.keep == 3'd0) begin
							st_q <= B_IDLE;
						end else begin
							w_q <= q_cmd.data;
							n_q <= q_cmd.keep;
							st_q <= B_CONV;
						end
					end
					CMD_MARK: begin
						n_q <= q_cmd.forced ? 3'd2 : 3'd1;
						st_q <= B_EMIT;
					end
					default: st_q <= B_IDLE;
				endcase
			end
		end
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < ColW'(LINE_LENGTH))
		else $error("line column out of range");

	a_nl_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_NL && adv) |=> (ov_q && oc_q == ChNl))
		else $error("newline not emitted");

	a_conv_len: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_CONV && cnt_q == 3'd3) |=> (st_q == B_EMIT && cnt_q == 3'd0))
		else $error("digit conversion did not hand over");

	a_nl_after_full: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_EMIT && adv && nl_hit) |=> (st_q == B_NL && col_q == '0))
		else $error("full line without newline");

endmodule
